// ----- sv/fxa_pkg.sv -----
// Shared types and constants of the fixed-point ALU.
`default_nettype none
package fxa_pkg;

  localparam int WORD_W = 32;
  localparam int MODE_W = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [WORD_W-1:0]        mag_t;
  typedef logic [MODE_W-1:0]        mode_t;

  localparam mode_t MODE_ADD      = 4'd0;
  localparam mode_t MODE_SUB      = 4'd1;
  localparam mode_t MODE_MUL      = 4'd2;
  localparam mode_t MODE_DIV      = 4'd3;
  localparam mode_t MODE_INC      = 4'd4;
  localparam mode_t MODE_DEC      = 4'd5;
  localparam mode_t MODE_MIN      = 4'd6;
  localparam mode_t MODE_MAX      = 4'd7;
  localparam mode_t MODE_TO_INT   = 4'd8;
  localparam mode_t MODE_FROM_INT = 4'd9;

  localparam word_t MAX_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t MIN_NEG = {1'b1, {(WORD_W-1){1'b0}}};

  // Result of an arithmetic unit: saturated word and overflow flag.
  typedef struct packed {
    logic  ovf;
    word_t value;
  } arith_t;

  // Results decided in the first stage, carried alongside the divider.
  typedef struct packed {
    mode_t mode;
    word_t value;
    logic  ovf;
    logic  dz;
    logic  gt;
    logic  lt;
    logic  eq;
  } side_t;

endpackage
`default_nettype wire

// ----- sv/fxa_if.sv -----
// Valid/ready channel interfaces for ALU requests and responses.
`default_nettype none
interface fxa_req_if;
  logic                  valid;
  logic                  ready;
  logic [3:0]            mode;
  logic signed [31:0]    operand_a;
  logic signed [31:0]    operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fxa_rsp_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    result;
  logic                  a_greater;
  logic                  a_less;
  logic                  a_equal;
  logic                  overflow;
  logic                  divide_by_zero;
  modport source (output valid, result, a_greater, a_less, a_equal, overflow,
                  divide_by_zero, input ready);
  modport sink   (input valid, result, a_greater, a_less, a_equal, overflow,
                  divide_by_zero, output ready);
endinterface
`default_nettype wire

// ----- sv/fxa_mul.sv -----
// Two-stage rounding, saturating fixed-point multiplier on magnitudes.
`default_nettype none
module fxa_mul #(
  parameter int FRAC_BITS = 8
) (
  input  wire                  clk,
  input  wire                  en,
  input  wire fxa_pkg::mag_t   mag_a,
  input  wire fxa_pkg::mag_t   mag_b,
  input  wire                  neg,
  output fxa_pkg::arith_t      res
);
  localparam int PW = 2 * fxa_pkg::WORD_W;

  logic [PW-1:0] prod;
  logic          prod_neg;
  logic [PW:0]   rounded;
  logic [PW:0]   shifted;
  logic [PW:0]   limit;
  logic          ovf;
  fxa_pkg::mag_t mag;

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= PW'(mag_a) * PW'(mag_b);
      prod_neg <= neg;
    end
  end

  always_comb begin
    rounded = {1'b0, prod} + ((PW+1)'(1) << (FRAC_BITS - 1));
    shifted = rounded >> FRAC_BITS;
    limit   = (PW+1)'(fxa_pkg::mag_t'(prod_neg ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS));
    ovf     = shifted > limit;
    mag     = ovf ? limit[fxa_pkg::WORD_W-1:0] : shifted[fxa_pkg::WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.ovf   <= ovf;
      res.value <= prod_neg ? -mag : mag;
    end
  end
endmodule
`default_nettype wire

// ----- sv/fxa_div.sv -----
// Restoring divider, one quotient bit per stage, rounding and saturating.
`default_nettype none
module fxa_div #(
  parameter int FRAC_BITS = 8
) (
  input  wire                  clk,
  input  wire                  en,
  input  wire fxa_pkg::mag_t   mag_a,
  input  wire fxa_pkg::mag_t   mag_b,
  input  wire                  neg,
  output fxa_pkg::arith_t      res
);
  localparam int W = fxa_pkg::WORD_W;
  localparam int N = W + FRAC_BITS;

  logic [W-1:0] rem_q [0:N];
  logic [N-1:0] quo   [0:N];
  logic [N-1:0] dvd   [0:N];
  logic [W-1:0] dsr   [0:N];
  logic         sgn   [0:N];

  assign rem_q[0] = '0;
  assign quo[0]   = '0;
  assign dvd[0]   = {mag_a, {FRAC_BITS{1'b0}}};
  assign dsr[0]   = mag_b;
  assign sgn[0]   = neg;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      trial = {rem_q[k], dvd[k][N-1]};
      diff  = trial - {1'b0, dsr[k]};
      ge    = trial >= {1'b0, dsr[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        quo[k+1]   <= {quo[k][N-2:0], ge};
        dvd[k+1]   <= {dvd[k][N-2:0], 1'b0};
        dsr[k+1]   <= dsr[k];
        sgn[k+1]   <= sgn[k];
      end
    end
  end

  logic         rnd;
  logic [N:0]   qr;
  logic [N:0]   limit;
  logic         ovf;
  logic [W-1:0] mag;

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  always_comb begin
    rnd   = {rem_q[N], 1'b0} >= {1'b0, dsr[N]};
    qr    = {1'b0, quo[N]} + (N+1)'(rnd);
    limit = (N+1)'(fxa_pkg::mag_t'(sgn[N] ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS));
    ovf   = qr > limit;
    mag   = ovf ? limit[W-1:0] : qr[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.ovf   <= ovf;
      res.value <= sgn[N] ? -mag : mag;
    end
  end
endmodule
`default_nettype wire

// ----- sv/fixed_point_alu_top.sv -----
// Top level of the pipelined signed fixed-point ALU.
//
//   channel   direction  payload
//   req_ch    in         mode, operand_a, operand_b
//   rsp_ch    out        result, a_greater, a_less, a_equal, overflow, divide_by_zero
//
// One transaction in and one out every cycle while responses are taken; the
// pipeline depth is set by the divider, which resolves one quotient bit per
// stage. All stages advance together: when the output register holds an
// untaken transaction, the whole pipeline holds and req_ch.ready drops.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none
module fixed_point_alu_top #(
  parameter int FRAC_BITS = 8
) (
  input wire       clk,
  input wire       rst,
  fxa_req_if.sink  req_ch,
  fxa_rsp_if.source rsp_ch
);
  localparam int W       = fxa_pkg::WORD_W;
  localparam int DIV_LAT = W + FRAC_BITS + 1;
  localparam int MUL_LAT = 2;
  localparam int PAD     = DIV_LAT - MUL_LAT;

  logic adv;
  logic out_valid;

  // Advance whenever the output register is empty or being taken.
  assign adv          = !out_valid || rsp_ch.ready;
  assign req_ch.ready = adv;

  // ---------------- Stage 1: decode, compare and the simple operations
  fxa_pkg::word_t a, b;
  fxa_pkg::side_t side_next;
  fxa_pkg::mag_t  mag_a_next, mag_b_next;
  logic           neg_next;
  logic [W-1:0]   sum, dif;
  logic           sa, sb;
  logic           from_ovf;

  assign a = req_ch.operand_a;
  assign b = req_ch.operand_b;

  always_comb begin
    sa         = a[W-1];
    sb         = b[W-1];
    mag_a_next = sa ? fxa_pkg::mag_t'(-a) : fxa_pkg::mag_t'(a);
    mag_b_next = sb ? fxa_pkg::mag_t'(-b) : fxa_pkg::mag_t'(b);
    neg_next   = sa ^ sb;
    sum        = a + b;
    dif        = a - b;
    from_ovf   = mag_a_next > (fxa_pkg::mag_t'(sa ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS)
                               >> FRAC_BITS);

    side_next       = '0;
    side_next.mode  = req_ch.mode;
    side_next.gt    = a > b;
    side_next.lt    = a < b;
    side_next.eq    = a == b;

    case (req_ch.mode)
      fxa_pkg::MODE_ADD: begin
        if (sa == sb && sum[W-1] != sa) begin
          side_next.ovf   = 1'b1;
          side_next.value = sa ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS;
        end else begin
          side_next.value = sum;
        end
      end
      fxa_pkg::MODE_SUB: begin
        if (sa != sb && dif[W-1] != sa) begin
          side_next.ovf   = 1'b1;
          side_next.value = sa ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS;
        end else begin
          side_next.value = dif;
        end
      end
      fxa_pkg::MODE_DIV: begin
        // Only used when the divisor is zero; the divider covers the rest.
        side_next.dz    = b == '0;
        side_next.value = (a == '0) ? '0 : (sa ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS);
      end
      fxa_pkg::MODE_INC: begin
        side_next.ovf   = a == fxa_pkg::MAX_POS;
        side_next.value = side_next.ovf ? a : a + 1'b1;
      end
      fxa_pkg::MODE_DEC: begin
        side_next.ovf   = a == fxa_pkg::MIN_NEG;
        side_next.value = side_next.ovf ? a : a - 1'b1;
      end
      fxa_pkg::MODE_MIN:     side_next.value = (a < b) ? a : b;
      fxa_pkg::MODE_MAX:     side_next.value = (a > b) ? a : b;
      fxa_pkg::MODE_TO_INT:  side_next.value = a >>> FRAC_BITS;
      fxa_pkg::MODE_FROM_INT: begin
        side_next.ovf   = from_ovf;
        side_next.value = from_ovf ? (sa ? fxa_pkg::MIN_NEG : fxa_pkg::MAX_POS)
                                   : (a <<< FRAC_BITS);
      end
      default: side_next.value = '0;
    endcase
  end

  logic           v1;
  fxa_pkg::side_t side1;
  fxa_pkg::mag_t  mag_a1, mag_b1;
  logic           neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1  <= side_next;
      mag_a1 <= mag_a_next;
      mag_b1 <= mag_b_next;
      neg1   <= neg_next;
    end
  end

  // ---------------- Arithmetic units
  fxa_pkg::arith_t div_res, mul_res;

  fxa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .en   (adv),
    .mag_a(mag_a1),
    .mag_b(mag_b1),
    .neg  (neg1),
    .res  (div_res)
  );

  fxa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .en   (adv),
    .mag_a(mag_a1),
    .mag_b(mag_b1),
    .neg  (neg1),
    .res  (mul_res)
  );

  // ---------------- Delay lines that keep pace with the divider
  logic            vline    [0:DIV_LAT-1];
  fxa_pkg::side_t  side_d   [0:DIV_LAT-1];
  fxa_pkg::arith_t mul_d    [0:PAD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) vline[i] <= 1'b0;
    end else if (adv) begin
      vline[0] <= v1;
      for (int i = 1; i < DIV_LAT; i++) vline[i] <= vline[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side1;
      for (int i = 1; i < DIV_LAT; i++) side_d[i] <= side_d[i-1];
      mul_d[0] <= mul_res;
      for (int i = 1; i < PAD; i++) mul_d[i] <= mul_d[i-1];
    end
  end

  // ---------------- Output register: pick the unit that owns the opcode
  fxa_pkg::side_t sd;
  fxa_pkg::word_t res_next;
  logic           ovf_next;

  assign sd = side_d[DIV_LAT-1];

  always_comb begin
    res_next = sd.value;
    ovf_next = sd.ovf;
    case (sd.mode)
      fxa_pkg::MODE_MUL: begin
        res_next = mul_d[PAD-1].value;
        ovf_next = mul_d[PAD-1].ovf;
      end
      fxa_pkg::MODE_DIV: begin
        if (!sd.dz) begin
          res_next = div_res.value;
          ovf_next = div_res.ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vline[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_ch.result         <= res_next;
      rsp_ch.a_greater      <= sd.gt;
      rsp_ch.a_less         <= sd.lt;
      rsp_ch.a_equal        <= sd.eq;
      rsp_ch.overflow       <= ovf_next;
      rsp_ch.divide_by_zero <= sd.dz;
    end
  end

  assign rsp_ch.valid = out_valid;

`ifndef SYNTHESIS
  // Exactly one compare flag on every delivered transaction.
  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({rsp_ch.a_greater, rsp_ch.a_less, rsp_ch.a_equal}))
    else $error("compare flags not one-hot");

  // Division by zero never reports overflow as well.
  a_dz_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rsp_ch.divide_by_zero && rsp_ch.overflow))
    else $error("divide_by_zero with overflow");

  // A held output must not be overwritten by the advancing pipeline.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp_ch.ready) |=> (out_valid && $stable(rsp_ch.result)))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/fxa_tb_if.sv -----
// Request and response records shared by the testbench processes.
`timescale 1ns / 1ps
package fxa_tb_types;

  // One request as the driver holds it.
  typedef struct {
    fxa_pkg::mode_t mode;
    fxa_pkg::word_t a;
    fxa_pkg::word_t b;
  } alu_req_t;

  // One response as the checker compares it.
  typedef struct {
    fxa_pkg::word_t result;
    logic  gt;
    logic  lt;
    logic  eq;
    logic  ovf;
    logic  dz;
  } alu_rsp_t;
endpackage

// ----- tb/sv/tb_fixed_point_alu_top.sv -----
// Self-checking testbench of the fixed-point ALU top level.
`timescale 1ns / 1ps
module tb_fixed_point_alu_top;

  localparam int FRAC = 8;
  localparam int LATENCY = fxa_pkg::WORD_W + FRAC + 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int N_RANDOM = 800;

  logic clk;
  logic rst;

  fxa_req_if req_ch ();
  fxa_rsp_if rsp_ch ();

  fixed_point_alu_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .req_ch(req_ch), .rsp_ch(rsp_ch)
  );

  fxa_tb_types::alu_req_t pending_reqs[$];
  fxa_tb_types::alu_rsp_t expected_rsps[$];
  int       err_count;
  int       sent_count;
  int       got_count;
  int       queued_count;
  int       ovf_seen;
  int       dz_seen;
  bit       hold_off;  // long receiver stall requested by the stimulus
  bit       req_fire;  // request taken at the last rising edge
  bit       rsp_fire;  // response taken at the last rising edge

  // Compute the exact fixed-point response of one request.
  function automatic fxa_tb_types::alu_rsp_t alu_predict(fxa_tb_types::alu_req_t r);
    fxa_tb_types::alu_rsp_t o;
    logic signed [127:0] wa, wb, wide, quo, rem, m;
    logic signed [127:0] lim_hi, lim_lo;
    o.gt = r.a > r.b;
    o.lt = r.a < r.b;
    o.eq = r.a == r.b;
    o.ovf = 1'b0;
    o.dz = 1'b0;
    o.result = '0;
    wa = r.a;
    wb = r.b;
    lim_hi = fxa_pkg::MAX_POS;
    lim_lo = fxa_pkg::MIN_NEG;
    wide = 0;
    case (r.mode)
      fxa_pkg::MODE_ADD: wide = wa + wb;
      fxa_pkg::MODE_SUB: wide = wa - wb;
      fxa_pkg::MODE_MUL: begin
        // round the magnitude half away from zero
        m = wa * wb;
        if (m < 0) wide = -((-m + (128'sd1 <<< (FRAC - 1))) >>> FRAC);
        else wide = (m + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
      end
      fxa_pkg::MODE_DIV: begin
        if (r.b == 0) begin
          o.dz = 1'b1;
          wide = (r.a == 0) ? 0 : (r.a < 0 ? lim_lo : lim_hi);
        end else begin
          m = (wa < 0 ? -wa : wa) <<< FRAC;
          quo = m / (wb < 0 ? -wb : wb);
          rem = m % (wb < 0 ? -wb : wb);
          if (2 * rem >= (wb < 0 ? -wb : wb)) quo = quo + 1;
          wide = ((wa < 0) != (wb < 0)) ? -quo : quo;
        end
      end
      fxa_pkg::MODE_INC: wide = wa + 1;
      fxa_pkg::MODE_DEC: wide = wa - 1;
      fxa_pkg::MODE_MIN: wide = o.lt ? wa : wb;
      fxa_pkg::MODE_MAX: wide = o.gt ? wa : wb;
      fxa_pkg::MODE_TO_INT: wide = wa >>> FRAC;
      fxa_pkg::MODE_FROM_INT: wide = wa <<< FRAC;
      default: wide = 0;
    endcase
    if (wide > lim_hi) begin
      o.ovf = 1'b1;
      wide = lim_hi;
    end else if (wide < lim_lo) begin
      o.ovf = 1'b1;
      wide = lim_lo;
    end
    o.result = wide[fxa_pkg::WORD_W-1:0];
    return o;
  endfunction

  task automatic queue_req(fxa_pkg::mode_t md, fxa_pkg::word_t a, fxa_pkg::word_t b);
    fxa_tb_types::alu_req_t r;
    r.mode = md;
    r.a = a;
    r.b = b;
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  // Pick an operand biased toward edges and small magnitudes.
  function automatic fxa_pkg::word_t pick_operand();
    case ($urandom_range(0, 9))
      0: return fxa_pkg::MAX_POS;
      1: return fxa_pkg::MIN_NEG;
      2: return fxa_pkg::word_t'(0);
      3: return fxa_pkg::word_t'($urandom_range(0, 2)) - 1;
      4, 5: return fxa_pkg::word_t'($signed($urandom_range(0, 8191)) - 4096);
      6: return fxa_pkg::word_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return fxa_pkg::word_t'($urandom);
    endcase
  endfunction

  // Draw the idle gap before the next item on one side; most often there is none.
  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 17)) : 0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Driver: present queued requests at the falling edge, with random gaps.
  int send_gap;
  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = '0;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    send_gap = 0;
  end

  always @(negedge clk) begin
    fxa_tb_types::alu_req_t r;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      // hold an offered transaction until it is taken
      if (req_fire) send_gap = draw_gap();
      if (send_gap > 0 || pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        r = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.mode <= r.mode;
        req_ch.operand_a <= r.a;
        req_ch.operand_b <= r.b;
      end
    end
  end

  // Record the expectation at the accepting edge.
  always @(posedge clk) begin
    req_fire <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      fxa_tb_types::alu_req_t r;
      r.mode = req_ch.mode;
      r.a = req_ch.operand_a;
      r.b = req_ch.operand_b;
      expected_rsps.push_back(alu_predict(r));
      sent_count++;
    end
  end

  // Receiver: random stalls, plus one long hold-off.
  int recv_gap;
  initial begin
    rsp_ch.ready = 1'b0;
    recv_gap = 0;
  end

  always @(negedge clk) begin
    if (rst || hold_off) begin
      rsp_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_fire) begin
      recv_gap = draw_gap();
      rsp_ch.ready <= (recv_gap == 0);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each accepted response with the oldest expectation.
  always @(posedge clk) begin
    rsp_fire <= !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      fxa_tb_types::alu_rsp_t w;
      got_count++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", rsp_ch.result, 32'h0);
      end else begin
        w = expected_rsps.pop_front();
        if (rsp_ch.result !== w.result) report_mismatch("result", rsp_ch.result, w.result);
        if (rsp_ch.a_greater !== w.gt)
          report_mismatch("a_greater", 32'(rsp_ch.a_greater), 32'(w.gt));
        if (rsp_ch.a_less !== w.lt)
          report_mismatch("a_less", 32'(rsp_ch.a_less), 32'(w.lt));
        if (rsp_ch.a_equal !== w.eq)
          report_mismatch("a_equal", 32'(rsp_ch.a_equal), 32'(w.eq));
        if (rsp_ch.overflow !== w.ovf)
          report_mismatch("overflow", 32'(rsp_ch.overflow), 32'(w.ovf));
        if (rsp_ch.divide_by_zero !== w.dz)
          report_mismatch("divide_by_zero", 32'(rsp_ch.divide_by_zero), 32'(w.dz));
        if (w.ovf) ovf_seen++;
        if (w.dz) dz_seen++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_fixed_point_alu_top: done, errors");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    hold_off = 1'b0;
    wait (sent_count >= 40);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    fxa_pkg::mode_t md;
    err_count = 0;
    sent_count = 0;
    got_count = 0;
    queued_count = 0;
    ovf_seen = 0;
    dz_seen = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every opcode, saturation, division by zero, ties, rounding.
    queue_req(fxa_pkg::MODE_ADD, fxa_pkg::MAX_POS, fxa_pkg::word_t'(1));
    queue_req(fxa_pkg::MODE_ADD, fxa_pkg::MIN_NEG, fxa_pkg::word_t'(-1));
    queue_req(fxa_pkg::MODE_SUB, fxa_pkg::MIN_NEG, fxa_pkg::word_t'(1));
    queue_req(fxa_pkg::MODE_SUB, fxa_pkg::MAX_POS, fxa_pkg::word_t'(-1));
    queue_req(fxa_pkg::MODE_SUB, fxa_pkg::word_t'(0), fxa_pkg::MIN_NEG);
    queue_req(fxa_pkg::MODE_MUL, fxa_pkg::MAX_POS, fxa_pkg::MAX_POS);
    queue_req(fxa_pkg::MODE_MUL, fxa_pkg::MIN_NEG, fxa_pkg::MAX_POS);
    queue_req(fxa_pkg::MODE_MUL, fxa_pkg::MIN_NEG, fxa_pkg::word_t'(-256));
    queue_req(fxa_pkg::MODE_MUL, fxa_pkg::word_t'(1), fxa_pkg::word_t'(128));
    queue_req(fxa_pkg::MODE_MUL, fxa_pkg::word_t'(-1), fxa_pkg::word_t'(128));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::word_t'(5), fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::word_t'(-5), fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::word_t'(0), fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::MAX_POS, fxa_pkg::word_t'(1));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::MIN_NEG, fxa_pkg::word_t'(-256));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::word_t'(1), fxa_pkg::word_t'(512));
    queue_req(fxa_pkg::MODE_DIV, fxa_pkg::word_t'(-1), fxa_pkg::word_t'(512));
    queue_req(fxa_pkg::MODE_INC, fxa_pkg::MAX_POS, fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_DEC, fxa_pkg::MIN_NEG, fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_MIN, fxa_pkg::word_t'(7), fxa_pkg::word_t'(7));
    queue_req(fxa_pkg::MODE_MAX, fxa_pkg::MIN_NEG, fxa_pkg::MAX_POS);
    queue_req(fxa_pkg::MODE_TO_INT, fxa_pkg::word_t'(-1), fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_FROM_INT, fxa_pkg::word_t'(32'h0080_0000), fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::MODE_FROM_INT, fxa_pkg::word_t'(-32'sh0080_0001),
              fxa_pkg::word_t'(0));
    queue_req(fxa_pkg::mode_t'(4'hF), fxa_pkg::word_t'(3), fxa_pkg::word_t'(-3));

    // Random: mostly defined opcodes, some unused codes.
    for (int i = 0; i < N_RANDOM; i++) begin
      md = ($urandom_range(0, 19) == 0) ? fxa_pkg::mode_t'($urandom_range(10, 15))
                                        : fxa_pkg::mode_t'($urandom_range(0, 9));
      queue_req(md, pick_operand(), ($urandom_range(0, 15) == 0) ? fxa_pkg::word_t'(0)
                                                                 : pick_operand());
      while (pending_reqs.size() > 64) @(negedge clk);
    end

    // Wait for every queued transaction to come back, then catch stragglers.
    wait (got_count >= queued_count);
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d requests, %0d responses, %0d saturated, %0d divide by zero",
             sent_count, got_count, ovf_seen, dz_seen);
    if (expected_rsps.size() != 0) begin
      $display("%0d responses never arrived", expected_rsps.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_fixed_point_alu_top: done, clean");
    end else begin
      $display("tb_fixed_point_alu_top: done, errors");
    end
    $finish;
  end

endmodule
